// File: hdl/ecg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecg_pkg: shared types and helpers for the edge crossing generator
// Coordinate widths, the command and status words between the controller
// and the datapath, and the pixel-center arithmetic used by the datapath.
// ---------------------------------------------------------------------------
package ecg_pkg;

	// coordinate format, 5.6 fixed point inside the glyph grid
	localparam int CoordW = 11;
	localparam int GridPixelsDefault = 32;

	// restoring divider: one quotient bit per cycle
	localparam int DivSteps = CoordW;
	localparam int DivCntW = $clog2(DivSteps);

	// pixel-center arithmetic
	localparam logic [CoordW-1:0] CenterOff = CoordW'(32);
	localparam logic [CoordW-1:0] PixelStep = CoordW'(64);
	localparam logic [CoordW-1:0] FracMask = CoordW'(63);

	typedef logic [CoordW-1:0] coord_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture a new segment
		logic setup;    // prepare the pass selected by pass
		logic pass;     // 0 row pass, 1 column pass
		logic mul;      // form offset times delta
		logic div_step; // one restoring division step
		logic emit;     // write the crossing into the output register
	} ecg_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pass_has; // selected pass has at least one crossing
		logic more;     // another center lies above the low endpoint
		logic out_free; // output register can take a word this cycle
	} ecg_sts_t;

	// largest pixel center not above hi (valid when hi >= 32)
	function automatic coord_t crossing_top(input coord_t hi);
		coord_t d;
		d = hi - CenterOff;
		return (d & ~FracMask) + CenterOff;
	endfunction

	// a pass has a crossing when some center lies in (lo, hi]
	function automatic logic pass_nonempty(input coord_t lo, input coord_t hi);
		return (hi >= CenterOff) && (crossing_top(hi) > lo);
	endfunction

endpackage

// File: hdl/edge_crossing_generator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// edge_crossing_generator_unit: scanline crossings of one line segment
// Turns one 5.6 segment into its row-center crossings, top down, and then
// its column-center crossings, each with the interpolated other coordinate.
//
//   channel  valid     stall      payload
//   in       in_valid  in_stall   x_start y_start x_end y_end
//   out      out_valid out_stall  axis scan_pos cross_pos last
//
// A segment takes one accept, one set-up per pass, and for each crossing one
// multiply, 11 divider steps and the output hand-off; the shared restoring
// divider yields one quotient bit per cycle.
// in_stall is high from the accept until the last word sits in the output
// register; a stall on out holds the word and halts the sequencer at its next emit.
// Reset clears the sequencer and the output valid; there is no clearing pass.
// ---------------------------------------------------------------------------
module edge_crossing_generator_unit
	import ecg_pkg::*;
#(
	parameter int GRID_PIXELS = GridPixelsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CoordW-1:0] x_start,
	input  logic [CoordW-1:0] y_start,
	input  logic [CoordW-1:0] x_end,
	input  logic [CoordW-1:0] y_end,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              axis,
	output logic [CoordW-1:0] scan_pos,
	output logic [CoordW-1:0] cross_pos,
	output logic              last
);

	ecg_cmd_t cmd;
	ecg_sts_t sts;

	// sequencer
	ecg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and output register
	ecg_dpath #(
		.GRID_PIXELS (GRID_PIXELS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.x_start   (x_start),
		.y_start   (y_start),
		.x_end     (x_end),
		.y_end     (y_end),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.axis      (axis),
		.scan_pos  (scan_pos),
		.cross_pos (cross_pos),
		.last      (last)
	);

endmodule

// File: hdl/ecg_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecg_ctrl: sequencer of the edge crossing generator
// Walks the row pass and then the column pass, and for every crossing runs
// a multiply, the division steps and the hand-off to the output register.
// ---------------------------------------------------------------------------
module ecg_ctrl
	import ecg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  ecg_sts_t sts,
	output ecg_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SETUP = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t              state_q;
	state_t              state_d;
	logic                pass_q;
	logic                pass_d;
	logic [DivCntW-1:0]  cnt_q;
	logic [DivCntW-1:0]  cnt_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		pass_d = pass_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.pass = pass_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					pass_d = 1'b0;
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				if (sts.pass_has) begin
					state_d = ST_MUL;
				end else if (!pass_q) begin
					pass_d = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == DivCntW'(DivSteps - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.more) begin
						state_d = ST_MUL;
					end else if (!pass_q) begin
						pass_d = 1'b1;
						state_d = ST_SETUP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			pass_q <= pass_d;
			cnt_q <= cnt_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// File: hdl/ecg_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecg_dpath: datapath of the edge crossing generator
// Holds the clamped segment, the pass set-up, one multiplier, a restoring
// divider and the output register.
// ---------------------------------------------------------------------------
module ecg_dpath
	import ecg_pkg::*;
#(
	parameter int GRID_PIXELS = GridPixelsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CoordW-1:0] x_start,
	input  logic [CoordW-1:0] y_start,
	input  logic [CoordW-1:0] x_end,
	input  logic [CoordW-1:0] y_end,
	input  ecg_cmd_t          cmd,
	output ecg_sts_t          sts,
	input  logic              out_stall,
	output logic              out_valid,
	output logic              axis,
	output logic [CoordW-1:0] scan_pos,
	output logic [CoordW-1:0] cross_pos,
	output logic              last
);

	localparam logic [CoordW-1:0] CoordMax = CoordW'(GRID_PIXELS * 64 - 1);

	coord_t              xs_q, ys_q, xe_q, ye_q;
	coord_t              a1_q, b1_q, da_q, dbmag_q, c_q;
	logic                neg_q;
	logic [CoordW-1:0]   rem_q, dvd_q, quo_q;
	logic                out_valid_q, axis_q, last_q;
	coord_t              scan_q, cross_q;

	coord_t              pa1, pa2, pb1, pb2, lo_a, hi_a, lo_b, hi_b;
	coord_t              x_lo, x_hi, offset;
	logic                has_col, more;
	logic [2*CoordW-1:0] prod;
	logic [CoordW:0]     trial, diff;
	logic                ge;
	logic [CoordW:0]     qsigned, vsum;

	// saturate one coordinate to the grid
	function automatic coord_t clamp(input coord_t v);
		return (v > CoordMax) ? CoordMax : v;
	endfunction

	// pass selection and endpoint ordering along the scan axis
	always_comb begin
		pa1 = cmd.pass ? xs_q : ys_q;
		pb1 = cmd.pass ? ys_q : xs_q;
		pa2 = cmd.pass ? xe_q : ye_q;
		pb2 = cmd.pass ? ye_q : xe_q;
		if (pa2 < pa1) begin
			lo_a = pa2; lo_b = pb2; hi_a = pa1; hi_b = pb1;
		end else begin
			lo_a = pa1; lo_b = pb1; hi_a = pa2; hi_b = pb2;
		end
		x_lo = (xe_q < xs_q) ? xe_q : xs_q;
		x_hi = (xe_q < xs_q) ? xs_q : xe_q;
	end

	assign has_col = pass_nonempty(x_lo, x_hi);

	// distance from the low endpoint to the current center
	assign offset = c_q - a1_q;
	assign more = (offset > PixelStep);
	assign prod = offset * dbmag_q;

	// restoring division step
	assign trial = {rem_q, dvd_q[CoordW-1]};
	assign ge = (trial >= {1'b0, da_q});
	assign diff = trial - {1'b0, da_q};

	// signed quotient added to the low endpoint's other coordinate
	assign qsigned = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
	assign vsum = {1'b0, b1_q} + qsigned;

	// segment capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xs_q <= clamp(x_start);
			ys_q <= clamp(y_start);
			xe_q <= clamp(x_end);
			ye_q <= clamp(y_end);
		end
	end

	// pass set-up, multiply, divide and center walk
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			a1_q <= lo_a;
			b1_q <= lo_b;
			da_q <= hi_a - lo_a;
			neg_q <= (hi_b < lo_b);
			dbmag_q <= (hi_b < lo_b) ? (lo_b - hi_b) : (hi_b - lo_b);
			c_q <= crossing_top(hi_a);
		end
		if (cmd.mul) begin
			rem_q <= prod[2*CoordW-1:CoordW];
			dvd_q <= prod[CoordW-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[CoordW-1:0] : trial[CoordW-1:0];
			dvd_q <= {dvd_q[CoordW-2:0], 1'b0};
			quo_q <= {quo_q[CoordW-2:0], ge};
		end
		if (cmd.emit) begin
			c_q <= c_q - PixelStep;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			axis_q <= cmd.pass;
			scan_q <= c_q;
			cross_q <= vsum[CoordW-1:0];
			last_q <= !more && (cmd.pass || !has_col);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// status back to the controller
	assign sts.pass_has = pass_nonempty(lo_a, hi_a);
	assign sts.more = more;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign axis = axis_q;
	assign scan_pos = scan_q;
	assign cross_pos = cross_q;
	assign last = last_q;

endmodule

// File: hdl/ecg_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecg_checker: port-level checks for the edge crossing generator
// Watches the top-level ports over time; attached to the top level by bind.
// ---------------------------------------------------------------------------
module ecg_checker
	import ecg_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              axis,
	input logic [CoordW-1:0] scan_pos,
	input logic [CoordW-1:0] cross_pos,
	input logic              last
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(axis) && $stable(scan_pos)
			&& $stable(cross_pos) && $stable(last))
		else $error("output word changed under stall");

	// every reported row or column sits on a pixel center
	a_center: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (scan_pos & FracMask) == CenterOff)
		else $error("scan position is not a pixel center");

	// an accepted segment always occupies the block for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	// a pending word that is not last leaves the segment still in work
	a_busy_before_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("block idle before the last word of a segment");

endmodule

bind edge_crossing_generator_unit ecg_checker u_ecg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.axis      (axis),
	.scan_pos  (scan_pos),
	.cross_pos (cross_pos),
	.last      (last)
);
